FILE: rtl/bgcs_pkg.sv
`default_nettype none

package bgcs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W     = 10;
	localparam int ROW_W     = 10;
	localparam int DIM_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int WIN_W     = 9;
	localparam int NSLOT     = 4;
	localparam int SLOT_W    = 2;
	localparam int LINE_W    = 2;

	// Result queue between the window stage and the output register
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;
	localparam int OCC_W      = FIFO_AW + 1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(64);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	// Result slots of one cell, in output order
	typedef enum logic [SLOT_W-1:0] {
		SLOT_UP_LEFT  = 2'd0,
		SLOT_UP_SELF  = 2'd1,
		SLOT_LOW_LEFT = 2'd2,
		SLOT_LOW_SELF = 2'd3
	} slot_t;

	typedef struct packed {
		logic [WIN_W-1:0] win;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [NSLOT-1:0] slots;
	} bgcs_rec_t;

	// Shift a new right-hand column in: t = top, m = middle, b = bottom
	function automatic logic [WIN_W-1:0] shift_col(input logic [WIN_W-1:0] win,
			input logic t, input logic m, input logic b);
		shift_col = {b, win[8:7], m, win[5:4], t, win[2:1]};
	endfunction

	// 4-5 rule on the eight neighbors of the window center
	function automatic logic smooth(input logic [WIN_W-1:0] win);
		logic [3:0] cnt;
		cnt = 4'd0;
		for (int i = 0; i < WIN_W; i++) begin
			if (i != 4)
				cnt = cnt + 4'(win[i]);
		end
		if (cnt > 4'd4)
			smooth = 1'b1;
		else if (cnt < 4'd4)
			smooth = 1'b0;
		else
			smooth = win[4];
	endfunction

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		if (v == '0)
			eff_dim = DIM_W'(1);
		else if (v > maxv)
			eff_dim = maxv;
		else
			eff_dim = v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/binary_grid_cave_smoothing.sv
`default_nettype none
// A cell's first smoothed word passes the stage-1 registers, queue and output register.
// The input takes one cell per cycle while the queue has room; the output port moves one
// word per cycle while out_ready is high; row-end and last-row cells give up to four words.
// Line stores share one 2-bit x MAX_WIDTH RAM, read and written once per cell.
// Reset: counters, window and queue clear; sizes return to 64 x 64; line RAM is not cleared.
module binary_grid_cave_smoothing (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bgcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bgcs_pkg::DIM_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               cell_wall,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [bgcs_pkg::COL_W-1:0]         out_col,
	output logic      [bgcs_pkg::ROW_W-1:0]         out_row,
	output logic                                    new_wall,
	output logic                                    map_done
);

	import bgcs_pkg::*;

	localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

	logic [DIM_W-1:0] grid_width_q, grid_height_q;
	logic [COL_W-1:0] col_count_q;
	logic [ROW_W-1:0] row_count_q;
	logic [WIN_W-1:0] window_q;

	logic             valid_s1, cell_s1, row_end_s1, last_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic              fwd_hit_s1;
	logic [LINE_W-1:0] fwd_data_s1;

	logic              in_accept, row_end, last_row;
	logic [DIM_W-1:0]  eff_w, eff_h;
	logic [OCC_W-1:0]  occ, inflight;
	logic [LINE_W-1:0] ram_rdata, line, wdata;
	logic              top, mid;
	logic [WIN_W-1:0]  base, win_new;
	bgcs_rec_t         rec;
	logic              push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= WIDTH_RESET;
			grid_height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input side: position and row/map end flags
	always_comb begin
		inflight  = occ + OCC_W'(valid_s1);
		in_ready  = inflight < OCC_W'(FIFO_DEPTH);
		in_accept = in_valid && in_ready;
		eff_w     = eff_dim(grid_width_q, MAX_W_DIM);
		eff_h     = eff_dim(grid_height_q, MAX_H_DIM);
		row_end   = (DIM_W'(col_count_q) + DIM_W'(1)) >= eff_w;
		last_row  = (DIM_W'(row_count_q) + DIM_W'(1)) >= eff_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (in_accept) begin
			if (row_end) begin
				col_count_q <= '0;
				row_count_q <= last_row ? '0 : row_count_q + ROW_W'(1);
			end else begin
				col_count_q <= col_count_q + COL_W'(1);
			end
		end
	end

	bgcs_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (wdata),
		.re    (in_accept),
		.raddr (col_count_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			valid_s1   <= in_accept;
			// read and write of the same column in one cycle: take the new word
			fwd_hit_s1 <= in_accept && valid_s1 && (col_s1 == col_count_q);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= wdata;
		if (in_accept) begin
			col_s1     <= col_count_q;
			row_s1     <= row_count_q;
			cell_s1    <= cell_wall;
			row_end_s1 <= row_end;
			last_s1    <= last_row;
		end
	end

	// Stage 1: line words back, shift the window, update the line stores
	always_comb begin
		line    = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
		top     = (row_s1 >= ROW_W'(2)) ? line[1] : 1'b1;
		mid     = (row_s1 != '0) ? line[0] : 1'b1;
		wdata   = {line[0], cell_s1};
		base    = (col_s1 == '0) ? '1 : window_q;
		win_new = shift_col(base, top, mid, cell_s1);

		rec.win   = win_new;
		rec.col   = col_s1;
		rec.row   = row_s1;
		rec.slots[SLOT_UP_LEFT]  = (row_s1 != '0) && (col_s1 != '0);
		rec.slots[SLOT_UP_SELF]  = (row_s1 != '0) && row_end_s1;
		rec.slots[SLOT_LOW_LEFT] = last_s1 && (col_s1 != '0);
		rec.slots[SLOT_LOW_SELF] = last_s1 && row_end_s1;
		push = valid_s1 && (rec.slots != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (valid_s1) begin
			window_q <= win_new;
		end
	end

	bgcs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (rec),
		.occ       (occ),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_col   (out_col),
		.out_row   (out_row),
		.new_wall  (new_wall),
		.map_done  (map_done)
	);

endmodule

`default_nettype wire

FILE: rtl/bgcs_ram.sv
`default_nettype none

module bgcs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/bgcs_emit.sv
`default_nettype none

module bgcs_emit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire bgcs_pkg::bgcs_rec_t            push_rec,
	output logic      [bgcs_pkg::OCC_W-1:0]     occ,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [bgcs_pkg::COL_W-1:0]     out_col,
	output logic      [bgcs_pkg::ROW_W-1:0]     out_row,
	output logic                                new_wall,
	output logic                                map_done
);

	import bgcs_pkg::*;

	bgcs_rec_t          rec_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0]   occ_q;
	logic [NSLOT-1:0]   done_q;

	logic             out_valid_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic             new_wall_q, map_done_q;

	bgcs_rec_t        head;
	logic [NSLOT-1:0] rem, sel_oh;
	slot_t            sel;
	logic             load, last, pop;
	logic [WIN_W-1:0] low, eval_win;
	logic [COL_W-1:0] res_col;
	logic [ROW_W-1:0] res_row;
	logic             res_done;

	always_comb begin
		head = rec_q[rd_ptr_q];
		rem  = head.slots & ~done_q;
		sel  = SLOT_UP_LEFT;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (rem[i])
				sel = slot_t'(i);
		end
		sel_oh = NSLOT'(1) << sel;
		last   = (rem & ~sel_oh) == '0;
		load   = (occ_q != '0) && (!out_valid_q || out_ready);
		pop    = load && last;
		low    = {3'b111, head.win[8:3]};

		unique case (sel)
			SLOT_UP_LEFT: begin
				res_col  = head.col - COL_W'(1);
				res_row  = head.row - ROW_W'(1);
				eval_win = head.win;
				res_done = 1'b0;
			end
			SLOT_UP_SELF: begin
				res_col  = head.col;
				res_row  = head.row - ROW_W'(1);
				eval_win = shift_col(head.win, 1'b1, 1'b1, 1'b1);
				res_done = 1'b0;
			end
			SLOT_LOW_LEFT: begin
				res_col  = head.col - COL_W'(1);
				res_row  = head.row;
				eval_win = low;
				res_done = 1'b0;
			end
			SLOT_LOW_SELF: begin
				res_col  = head.col;
				res_row  = head.row;
				eval_win = shift_col(low, 1'b1, 1'b1, 1'b1);
				res_done = 1'b1;
			end
			default: begin
				res_col  = head.col;
				res_row  = head.row;
				eval_win = head.win;
				res_done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push)
			rec_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			done_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (push && !pop)
				occ_q <= occ_q + OCC_W'(1);
			else if (pop && !push)
				occ_q <= occ_q - OCC_W'(1);
			// track slots already sent from the head record
			if (pop)
				done_q <= '0;
			else if (load)
				done_q <= done_q | sel_oh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_col_q  <= res_col;
			out_row_q  <= res_row;
			new_wall_q <= smooth(eval_win);
			map_done_q <= res_done;
		end
	end

	assign occ       = occ_q;
	assign out_valid = out_valid_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign new_wall  = new_wall_q;
	assign map_done  = map_done_q;

endmodule

`default_nettype wire

FILE: dv/cave_smooth_checker.sv
`default_nettype none

module cave_smooth_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [bgcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bgcs_pkg::DIM_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic                           cell_wall,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic [bgcs_pkg::COL_W-1:0]     out_col,
	input  wire logic [bgcs_pkg::ROW_W-1:0]     out_row,
	input  wire logic                           new_wall,
	input  wire logic                           map_done,
	output int                                  fail_count,
	output int                                  pending
);
	import bgcs_pkg::*;

	typedef struct {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             wall;
		logic             done;
	} smoothed_cell_t;

	smoothed_cell_t   smoothed_q[$];
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic             older_row[MAX_WIDTH];
	logic             prior_row[MAX_WIDTH];
	int unsigned      col_pos;
	int unsigned      row_pos;
	logic [WIN_W-1:0] win_bits;
	int               errors = 0;

	initial begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			older_row[i] = 1'b0;
			prior_row[i] = 1'b0;
		end
	end

	function automatic int unsigned active_dim(input logic [DIM_W-1:0] v,
			input int unsigned lim);
		if (v == '0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// Each window row drops its oldest column; the new column enters at the right.
	function automatic logic [WIN_W-1:0] slide_window(input logic [WIN_W-1:0] w,
			input logic t, input logic m, input logic b);
		logic [WIN_W-1:0] s;
		for (int k = 0; k < 3; k++) begin
			s[3*k]   = w[3*k+1];
			s[3*k+1] = w[3*k+2];
		end
		s[2] = t;
		s[5] = m;
		s[8] = b;
		return s;
	endfunction

	function automatic logic rule_4_5(input logic [WIN_W-1:0] w);
		int walls;
		walls = 0;
		for (int i = 0; i < WIN_W; i++) begin
			if (i != 4 && w[i])
				walls++;
		end
		if (walls > 4)
			return 1'b1;
		if (walls < 4)
			return 1'b0;
		return w[4];
	endfunction

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic emit(input int unsigned col, input int unsigned row,
			input logic [WIN_W-1:0] w, input logic done);
		smoothed_cell_t e;
		e.col = COL_W'(col);
		e.row = ROW_W'(row);
		e.wall = rule_4_5(w);
		e.done = done;
		smoothed_q.insert(smoothed_q.size(), e);
	endtask

	task automatic take_cell(input logic wall);
		int unsigned      w, h, c, r;
		logic             above2, above1, row_end, last_row;
		logic [WIN_W-1:0] low;
		w = active_dim(width_reg, MAX_WIDTH);
		h = active_dim(height_reg, MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		row_end = (c + 1 >= w);
		last_row = (r + 1 >= h);
		// Rows above the map read as walls.
		above2 = (r >= 2) ? older_row[c] : 1'b1;
		above1 = (r >= 1) ? prior_row[c] : 1'b1;
		older_row[c] = prior_row[c];
		prior_row[c] = wall;
		if (c == 0)
			win_bits = '1;
		win_bits = slide_window(win_bits, above2, above1, wall);
		if (r >= 1 && c >= 1)
			emit(c - 1, r - 1, win_bits, 1'b0);
		if (r >= 1 && row_end)
			emit(c, r - 1, slide_window(win_bits, 1'b1, 1'b1, 1'b1), 1'b0);
		if (last_row) begin
			// Flush the bottom row with walls below it.
			low = {3'b111, win_bits[8:3]};
			if (c >= 1)
				emit(c - 1, r, low, 1'b0);
			if (row_end)
				emit(c, r, slide_window(low, 1'b1, 1'b1, 1'b1), 1'b1);
		end
		if (row_end) begin
			col_pos = 0;
			row_pos = last_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_word();
		smoothed_cell_t e;
		if (smoothed_q.size() == 0) begin
			report($sformatf("unexpected word col %0d row %0d wall %0b done %0b",
				out_col, out_row, new_wall, map_done));
		end else begin
			e = smoothed_q.pop_front();
			if (out_col !== e.col || out_row !== e.row || new_wall !== e.wall ||
					map_done !== e.done)
				report($sformatf({"wrong word: got col %0d row %0d wall %0b done %0b, ",
					"want col %0d row %0d wall %0b done %0b"},
					out_col, out_row, new_wall, map_done,
					e.col, e.row, e.wall, e.done));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_pos = 0;
			row_pos = 0;
			win_bits = '0;
			smoothed_q.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GRID_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == CFG_GRID_HEIGHT)
					height_reg = cfg_data;
			end
			if (in_valid && in_ready)
				take_cell(cell_wall);
			if (out_valid && out_ready)
				check_word();
			pending <= smoothed_q.size();
			fail_count <= errors;
		end
	end

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;
	import bgcs_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cell_wall;
	logic                 out_valid;
	logic                 out_ready;
	logic [COL_W-1:0]     out_col;
	logic [ROW_W-1:0]     out_row;
	logic                 new_wall;
	logic                 map_done;
	int                   fail_count;
	int                   pending;

	// Raster position of the next cell, tracked so maps can be completed.
	int unsigned span_w, span_h, pos_c, pos_r;
	int          sent, density, gap_odds;
	bit          calm;

	binary_grid_cave_smoothing uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cell_wall (cell_wall),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_col   (out_col),
		.out_row   (out_row),
		.new_wall  (new_wall),
		.map_done  (map_done)
	);

	cave_smooth_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_wall  (cell_wall),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_col    (out_col),
		.out_row    (out_row),
		.new_wall   (new_wall),
		.map_done   (map_done),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("binary_grid_cave_smoothing: mismatch");
		$finish;
	end

	// Receiver: stall bursts of random length, stall rate drifts over time.
	initial begin
		int hold, odds;
		out_ready = 1'b0;
		hold = 0;
		odds = 2;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				odds = $urandom_range(0, 3);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) < odds) begin
				hold = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic rand_cell();
		return $urandom_range(0, 99) < density;
	endfunction

	task automatic cfg_write(input cfg_reg_t idx, input int unsigned val);
		int unsigned v, d;
		v = val & 32'h7FF;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		d = (v == 0) ? 1 : v;
		if (idx == CFG_GRID_WIDTH)
			span_w = (d > MAX_WIDTH) ? MAX_WIDTH : d;
		else
			span_h = (d > MAX_HEIGHT) ? MAX_HEIGHT : d;
		@(posedge clk);
	endtask

	task automatic send_cell(input logic v);
		if (!calm && $urandom_range(0, 7) < gap_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_wall <= v;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (pos_c + 1 >= span_w) begin
			pos_c = 0;
			pos_r = (pos_r + 1 >= span_h) ? 0 : pos_r + 1;
		end else begin
			pos_c++;
		end
	endtask

	task automatic finish_map();
		while (pos_c != 0 || pos_r != 0)
			send_cell(rand_cell());
	endtask

	task automatic send_map();
		send_cell(rand_cell());
		finish_map();
	endtask

	// Drop valid and hold until every smoothed word is back, then let the pipe empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int base, w, h, part;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GRID_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		cell_wall = 1'b0;
		calm = 1'b0;
		span_w = 64;
		span_h = 64;
		pos_c = 0;
		pos_r = 0;
		sent = 0;
		density = 50;
		gap_odds = 2;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-cell maps, then zero sizes acting as one
		cfg_write(CFG_GRID_WIDTH, 1);
		cfg_write(CFG_GRID_HEIGHT, 1);
		send_cell(1'b0);
		send_cell(1'b1);
		settle();
		cfg_write(CFG_GRID_WIDTH, 0);
		cfg_write(CFG_GRID_HEIGHT, 0);
		send_cell(1'b1);

		// checkerboard: the center sees exactly four walls and keeps its value
		settle();
		cfg_write(CFG_GRID_WIDTH, 3);
		cfg_write(CFG_GRID_HEIGHT, 3);
		for (int i = 0; i < 9; i++)
			send_cell(i % 2 == 0);
		settle();
		cfg_write(CFG_GRID_WIDTH, 4);
		cfg_write(CFG_GRID_HEIGHT, 2);
		repeat (8) send_cell(1'b0);

		// shrink both sizes mid-map: current column ends the row, current row is last
		settle();
		cfg_write(CFG_GRID_WIDTH, 6);
		cfg_write(CFG_GRID_HEIGHT, 5);
		repeat (15) send_cell(rand_cell());
		settle();
		cfg_write(CFG_GRID_WIDTH, 3);
		cfg_write(CFG_GRID_HEIGHT, 2);
		finish_map();

		// grow height mid-map
		settle();
		cfg_write(CFG_GRID_WIDTH, 5);
		cfg_write(CFG_GRID_HEIGHT, 2);
		repeat (5) send_cell(rand_cell());
		settle();
		cfg_write(CFG_GRID_HEIGHT, 4);
		finish_map();

		// oversize values clamp to the maximum; shrink mid-map to close the map early
		settle();
		cfg_write(CFG_GRID_WIDTH, 2047);
		cfg_write(CFG_GRID_HEIGHT, 2);
		repeat (6) send_cell(rand_cell());
		settle();
		cfg_write(CFG_GRID_WIDTH, 4);
		finish_map();
		settle();
		cfg_write(CFG_GRID_WIDTH, 2);
		cfg_write(CFG_GRID_HEIGHT, 2047);
		repeat (6) send_cell(rand_cell());
		settle();
		cfg_write(CFG_GRID_HEIGHT, 4);
		finish_map();

		base = sent;
		while (sent - base < 70) begin
			settle();
			if (sent - base >= 50)
				calm = 1'b1;
			gap_odds = $urandom_range(0, 3);
			case ($urandom_range(0, 3))
				0: density = 15;
				1: density = 45;
				2: density = 55;
				default: density = 85;
			endcase
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			h = (w > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5);
			cfg_write(CFG_GRID_WIDTH, w);
			cfg_write(CFG_GRID_HEIGHT, h);
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 3) == 0 && span_w * span_h > 1) begin
					// width may only shrink mid-map
					part = $urandom_range(1, span_w * span_h - 1);
					repeat (part) send_cell(rand_cell());
					settle();
					cfg_write(CFG_GRID_WIDTH, $urandom_range(1, span_w));
					cfg_write(CFG_GRID_HEIGHT, $urandom_range(1, 5));
					finish_map();
				end else begin
					send_map();
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("binary_grid_cave_smoothing: match");
		else
			$display("binary_grid_cave_smoothing: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

FILE: binary_grid_cave_smoothing.f
rtl/bgcs_pkg.sv
rtl/bgcs_ram.sv
rtl/bgcs_emit.sv
rtl/binary_grid_cave_smoothing.sv
dv/cave_smooth_checker.sv
dv/tb.sv
